// ----- rtl/ubd_pkg.sv -----
// Shared types and constants for the USART baud divisor calculator.
// No dependencies; imported by every module of the block.
package ubd_pkg;

    // Field widths
    localparam int CLK_W       = 28;
    localparam int BAUD_W      = 24;
    localparam int NUM_W       = 32;
    localparam int MANT_W      = 26;
    localparam int MANT_KEEP_W = 12;
    localparam int FRAC_W      = 4;
    localparam int WORD_W      = 16;
    localparam int REM_W       = 7;
    localparam int FX_W        = 11;
    localparam int IN_DATA_W   = 56;
    localparam int OUT_USER_W  = 2;

    // Divide-by-100 by reciprocal: q / 100 = (q * RECIP_100) >> RECIP_SHIFT for 32-bit q
    localparam logic [30:0] RECIP_100   = 31'h51EB851F;
    localparam int          RECIP_SHIFT = 37;

    // Divide-by-100 for the small fraction numerator (below 1650)
    localparam logic [10:0] FRAC_RECIP = 11'd1311;
    localparam int          FRAC_SHIFT = 17;

    localparam logic [6:0]  PCT_BASE     = 7'd100;
    localparam logic [10:0] ROUND_HALF   = 11'd50;
    localparam logic [3:0]  FRAC_MASK_8X  = 4'h7;
    localparam logic [3:0]  FRAC_MASK_16X = 4'hF;

    // Bit places in the result tuser
    localparam int USER_ZERO_BIT = 0;
    localparam int USER_OVF_BIT  = 1;

    // Payload of one divider stage
    typedef struct packed {
        logic [BAUD_W-1:0] rem;
        logic [NUM_W-1:0]  num;
        logic [BAUD_W-1:0] den;
        logic              by8;
        logic              zero;
    } div_t;

endpackage

// ----- rtl/ubd_div_stage.sv -----
// One restoring-division step: retires one quotient bit per stage.
// Depends on ubd_pkg for the stage payload type.
module ubd_div_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  ubd_pkg::div_t in_data,
    output logic          out_valid,
    output ubd_pkg::div_t out_data
);
    import ubd_pkg::*;

    logic              valid_reg;
    div_t              data_reg;
    div_t              data_next;
    logic [BAUD_W:0]   trial;
    logic [BAUD_W:0]   diff;
    logic              take;

    // Shift in the next numerator bit and try a subtract
    always_comb
    begin
        trial     = {in_data.rem, in_data.num[NUM_W-1]};
        diff      = trial - {1'b0, in_data.den};
        take      = (trial >= {1'b0, in_data.den});
        data_next = in_data;
        data_next.rem = take ? diff[BAUD_W-1:0] : trial[BAUD_W-1:0];
        data_next.num = {in_data.num[NUM_W-2:0], take};
    end

    // Advance valid with the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    // Hold payload unless advancing
    always_ff @(posedge clk)
    begin
        if (en && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- rtl/usart_baud_divisor_calc.sv -----
// USART fractional baud divisor calculator, pipelined: top level.
// Depends on ubd_pkg and ubd_div_stage.
//
// Usage:
//   s_tdata carries one request word: apb_clock_hz in bits 27:0, baud_rate
//   in bits 51:28, zeros above. m_tdata carries divisor_word; m_tuser holds
//   zero_rate_error (bit 0) and mantissa_overflow (bit 1).
//   cfg_we/cfg_wdata write oversample_by_eight (1 = 8x, 0 = 16x); write it
//   only while no request is in flight.
// Pipeline and throughput:
//   From accept to result: one stage scales the clock by 25 and
//   folds in the oversampling factor, a 32-stage restoring divider retires
//   one quotient bit per stage, two stages split off mantissa and remainder
//   by reciprocal multiply, and the output register takes the rounded word.
//   One word per cycle is accepted while the skid register is empty.
// Reset:
//   rst_n clears all valid bits and selects 16x oversampling.
// Stall:
//   When m_tready is low the pipeline keeps advancing until one extra word
//   sits in the skid register; s_tready then drops until the output drains.
module usart_baud_divisor_calc (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration
    input  logic                                cfg_we,
    input  logic                                cfg_wdata,     // oversample_by_eight
    // Request stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ubd_pkg::IN_DATA_W-1:0]       s_tdata,       // [27:0] apb_clock_hz, [51:28] baud_rate
    // Result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ubd_pkg::WORD_W-1:0]          m_tdata,       // [15:0] divisor_word
    output logic [ubd_pkg::OUT_USER_W-1:0]      m_tuser        // [0] zero_rate_error, [1] mantissa_overflow
);
    import ubd_pkg::*;

    localparam int NSTG = NUM_W;

    logic              by8_reg;
    logic              en;
    logic              in_fire;

    logic [CLK_W-1:0]  in_clk_hz;
    logic [BAUD_W-1:0] in_baud;
    logic [CLK_W+4:0]  clk_x25;
    div_t              s0_next;
    logic              s0_valid_reg;
    div_t              s0_reg;

    logic              stg_valid [NSTG+1];
    div_t              stg_data  [NSTG+1];

    logic [62:0]            m1_prod;
    logic                   m1_valid_reg;
    logic [MANT_W-1:0]      m1_mant_reg;
    logic [REM_W-1:0]       m1_qlo_reg;
    logic                   m1_by8_reg;
    logic                   m1_zero_reg;

    logic [13:0]            m2_hund;
    logic [REM_W-1:0]       m2_rem_next;
    logic                   m2_valid_reg;
    logic [REM_W-1:0]       m2_rem_reg;
    logic [MANT_KEEP_W-1:0] m2_mant_reg;
    logic                   m2_ovf_reg;
    logic                   m2_by8_reg;
    logic                   m2_zero_reg;

    logic [FX_W-1:0]        fx;
    logic [2*FX_W-1:0]      fx_prod;
    logic [4:0]             frac_full;
    logic [FRAC_W-1:0]      frac;
    logic [WORD_W-1:0]      word_next;
    logic [OUT_USER_W-1:0]  user_next;

    logic                   out_valid_reg;
    logic [WORD_W-1:0]      out_word_reg;
    logic [OUT_USER_W-1:0]  out_user_reg;
    logic                   skid_valid_reg;
    logic [WORD_W-1:0]      skid_word_reg;
    logic [OUT_USER_W-1:0]  skid_user_reg;
    logic                   out_free;
    logic                   last_fire;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            by8_reg <= 1'b0;
        else if (cfg_we)
            by8_reg <= cfg_wdata;
    end

    // Advance the whole pipeline while the skid register is empty
    assign en       = !skid_valid_reg;
    assign s_tready = en;
    assign in_fire  = s_tvalid && s_tready;

    // Stage 0: scale clock by 25 and divide by the oversampling factor's shift
    always_comb
    begin
        in_clk_hz = s_tdata[CLK_W-1:0];
        in_baud   = s_tdata[CLK_W+BAUD_W-1:CLK_W];
        clk_x25   = ({5'b0, in_clk_hz} << 4) + ({5'b0, in_clk_hz} << 3) + {5'b0, in_clk_hz};
        s0_next.rem  = '0;
        s0_next.num  = by8_reg ? clk_x25[CLK_W+4:1] : {1'b0, clk_x25[CLK_W+4:2]};
        s0_next.den  = in_baud;
        s0_next.by8  = by8_reg;
        s0_next.zero = (in_baud == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (en)
            s0_valid_reg <= in_fire;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            s0_reg <= s0_next;
    end

    assign stg_valid[0] = s0_valid_reg;
    assign stg_data[0]  = s0_reg;

    // Divider: one quotient bit per stage
    for (genvar i = 0; i < NSTG; i++)
    begin : g_div
        ubd_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (stg_valid[i]),
            .in_data   (stg_data[i]),
            .out_valid (stg_valid[i+1]),
            .out_data  (stg_data[i+1])
        );
    end

    // Stage M1: mantissa = quotient / 100 by reciprocal multiply
    assign m1_prod = {31'b0, stg_data[NSTG].num} * {32'b0, RECIP_100};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m1_valid_reg <= 1'b0;
        else if (en)
            m1_valid_reg <= stg_valid[NSTG];
    end

    always_ff @(posedge clk)
    begin
        if (en && stg_valid[NSTG])
        begin
            m1_mant_reg <= m1_prod[RECIP_SHIFT+MANT_W-1:RECIP_SHIFT];
            m1_qlo_reg  <= stg_data[NSTG].num[REM_W-1:0];
            m1_by8_reg  <= stg_data[NSTG].by8;
            m1_zero_reg <= stg_data[NSTG].zero;
        end
    end

    // Stage M2: remainder is below 100, so the low seven bits suffice
    always_comb
    begin
        m2_hund     = {7'b0, m1_mant_reg[REM_W-1:0]} * {7'b0, PCT_BASE};
        m2_rem_next = m1_qlo_reg - m2_hund[REM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m2_valid_reg <= 1'b0;
        else if (en)
            m2_valid_reg <= m1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en && m1_valid_reg)
        begin
            m2_rem_reg  <= m2_rem_next;
            m2_mant_reg <= m1_mant_reg[MANT_KEEP_W-1:0];
            m2_ovf_reg  <= |m1_mant_reg[MANT_W-1:MANT_KEEP_W];
            m2_by8_reg  <= m1_by8_reg;
            m2_zero_reg <= m1_zero_reg;
        end
    end

    // Round the fraction, drop its carry, and assemble the word
    always_comb
    begin
        fx        = m2_by8_reg ? ({1'b0, m2_rem_reg, 3'b0} + ROUND_HALF)
                               : ({m2_rem_reg, 4'b0} + ROUND_HALF);
        fx_prod   = {11'b0, fx} * {11'b0, FRAC_RECIP};
        frac_full = fx_prod[FRAC_SHIFT+4:FRAC_SHIFT];
        frac      = frac_full[FRAC_W-1:0] & (m2_by8_reg ? FRAC_MASK_8X : FRAC_MASK_16X);
        word_next = m2_zero_reg ? '0 : ({m2_mant_reg, 4'b0} | {12'b0, frac});
        user_next = '0;
        user_next[USER_ZERO_BIT] = m2_zero_reg;
        user_next[USER_OVF_BIT]  = m2_ovf_reg && !m2_zero_reg;
    end

    // Output register with a skid word behind it
    assign out_free  = !out_valid_reg || m_tready;
    assign last_fire = en && m2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || last_fire;
            skid_valid_reg <= 1'b0;
        end
        else if (last_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_word_reg <= skid_word_reg;
                out_user_reg <= skid_user_reg;
            end
            else if (last_fire)
            begin
                out_word_reg <= word_next;
                out_user_reg <= user_next;
            end
        end
        else if (last_fire)
        begin
            skid_word_reg <= word_next;
            skid_user_reg <= user_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_word_reg;
    assign m_tuser  = out_user_reg;

endmodule

// ----- rtl/ubd_checker.sv -----
// Port-level checks for the USART baud divisor calculator, bound to the top.
// Depends on ubd_pkg and on usart_baud_divisor_calc.
module ubd_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [ubd_pkg::WORD_W-1:0]      m_tdata,
    input logic [ubd_pkg::OUT_USER_W-1:0]  m_tuser
);
    import ubd_pkg::*;

    // A stalled result word holds its data
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // A zero-rate result carries a zero word
    a_zero_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[USER_ZERO_BIT] |-> m_tdata == '0)
        else $error("zero-rate result with nonzero word");

    // Zero-rate error and mantissa overflow never come together
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[USER_ZERO_BIT] && m_tuser[USER_OVF_BIT]))
        else $error("both result flags set");

    // Input back-pressure only follows a stalled output
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> $past(m_tvalid && !m_tready))
        else $error("input stalled without output stall");

endmodule

bind usart_baud_divisor_calc ubd_checker u_ubd_checker (.*);
